FILE: hdl/srt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sharded reference-count table: shared package
// Geometry constants, derived widths, operation and status codes, the stored
// entry layout and the write request that the sequencer sends to the store.
// ----------------------------------------------------------------------------
package srt_pkg;

	// Table geometry.
	localparam int BANKS            = 16;
	localparam int ENTRIES_PER_BANK = 16;
	localparam int BANK_SHIFT       = 6;

	// Fixed field widths.
	localparam int KEY_W    = 48;
	localparam int CNT_W    = 16;
	localparam int MODE_W   = 3;
	localparam int STATUS_W = 2;

	// Derived widths.
	localparam int TOTAL_ENTRIES = BANKS * ENTRIES_PER_BANK;
	localparam int ADDR_W = (TOTAL_ENTRIES > 1) ? $clog2(TOTAL_ENTRIES) : 1;
	localparam int BANK_W = (BANKS > 1) ? $clog2(BANKS) : 1;
	localparam int SLOT_W = (ENTRIES_PER_BANK > 1) ? $clog2(ENTRIES_PER_BANK) : 1;

	// Count limits.
	localparam logic signed [CNT_W-1:0] CNT_MAX  = {1'b0, {(CNT_W-1){1'b1}}};
	localparam logic signed [CNT_W-1:0] CNT_MIN  = {1'b1, {(CNT_W-1){1'b0}}};
	localparam logic signed [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
	localparam logic signed [CNT_W-1:0] CNT_ZERO = '0;

	// Operation codes.
	typedef enum logic [MODE_W-1:0] {
		MODE_ADD_INT    = 3'd0,
		MODE_ADD_CLIENT = 3'd1,
		MODE_VISIT_UP   = 3'd2,
		MODE_VISIT_DOWN = 3'd3,
		MODE_CLAIM      = 3'd4,
		MODE_UNCLAIM    = 3'd5
	} mode_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		STS_OK        = 2'd0,
		STS_NOT_FOUND = 2'd1,
		STS_NEGATIVE  = 2'd2,
		STS_REFUSED   = 2'd3
	} status_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_MOD,
		SEQ_SCAN,
		SEQ_DRAIN,
		SEQ_DECIDE
	} seq_state_t;

	// One stored entry.
	typedef struct packed {
		logic [KEY_W-1:0]        key;
		logic signed [CNT_W-1:0] visits;
		logic signed [CNT_W-1:0] claims;
		logic                    free_flag;
		logic                    client;
	} entry_t;

	// Write request into the entry store.
	typedef struct packed {
		logic              wr_en;
		logic              set_valid;
		logic              clr_valid;
		logic [ADDR_W-1:0] addr;
		entry_t            data;
	} store_wr_t;

endpackage
`default_nettype wire

FILE: hdl/srt_entry_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sharded reference-count table: entry store
// Entry memory with one write port and one registered read port, plus one
// valid flip-flop per entry that reset clears.
// ----------------------------------------------------------------------------
module srt_entry_store (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [srt_pkg::ADDR_W-1:0] rd_addr,
	input  srt_pkg::store_wr_t         wr,
	output srt_pkg::entry_t            rd_data,
	output logic                       rd_valid
);
	import srt_pkg::*;

	entry_t                   mem [TOTAL_ENTRIES];
	logic [TOTAL_ENTRIES-1:0] valid_q;
	entry_t                   rd_data_q;
	logic                     rd_valid_q;

	// Entry memory: write, then registered read.
	always_ff @(posedge clk) begin
		if (wr.wr_en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data_q <= mem[rd_addr];
	end

	// Valid bits and their registered read, aligned with the memory data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr.set_valid) begin
				valid_q[wr.addr] <= 1'b1;
			end else if (wr.clr_valid) begin
				valid_q[wr.addr] <= 1'b0;
			end
			rd_valid_q <= valid_q[rd_addr];
		end
	end

	assign rd_data  = rd_data_q;
	assign rd_valid = rd_valid_q;

endmodule
`default_nettype wire

FILE: hdl/sharded_refcount_table.sv
`timescale 1ns / 1ps
`default_nettype none
// Flow: an accepted word goes through the bank reduction (one 6-bit key digit per step, only when BANKS
// is not a power of two), the bank scan, a drain step and the decision; unused modes go straight to the decision.
// One word at a time: a new word is taken only after the decision, and the bank scan reads
// one entry per cycle through the single read port of the entry memory.
// Reset: asynchronous, clears all valid bits and the sequencer at once; no clearing pass.
// ----------------------------------------------------------------------------
// Sharded reference-count table
// Keys pick a bank, the bank is scanned for the key and a free slot, and one
// shared count unit applies the saturating step before the entry is written.
// ----------------------------------------------------------------------------
module sharded_refcount_table (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [srt_pkg::MODE_W-1:0]        mode,
	input  logic [srt_pkg::KEY_W-1:0]         key,
	input  logic                              free_on_release,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [srt_pkg::STATUS_W-1:0]      status,
	output logic                              released,
	output logic                              release_free,
	output logic                              release_client,
	output logic signed [srt_pkg::CNT_W-1:0]  visits_now,
	output logic signed [srt_pkg::CNT_W-1:0]  claims_now
);
	import srt_pkg::*;

	// Bank reduction constants.
	localparam bit  BANK_POW2 = ((BANKS & (BANKS - 1)) == 0);
	localparam int  SRC_W     = KEY_W - BANK_SHIFT;
	localparam int  DIG_W     = 6;
	localparam int  NDIG      = (SRC_W + DIG_W - 1) / DIG_W;
	localparam int  PAD_W     = NDIG * DIG_W;
	localparam int  DG_W      = (NDIG > 1) ? $clog2(NDIG) : 1;
	localparam logic [DG_W-1:0]   DG_LAST   = DG_W'(NDIG - 1);
	localparam logic [BANK_W:0]   BANKS_C   = (BANK_W + 1)'(BANKS);
	localparam logic [BANK_W-1:0] BANK_MASK = BANK_W'(BANKS - 1);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(ENTRIES_PER_BANK - 1);
	localparam logic [ADDR_W:0]   EPB_C     = (ADDR_W + 1)'(ENTRIES_PER_BANK);

	// Remainder step over one digit, one bit at a time.
	function automatic logic [BANK_W-1:0] mod_step(input logic [BANK_W-1:0] r,
			input logic [DIG_W-1:0] d);
		logic [BANK_W:0]   t;
		logic [BANK_W-1:0] acc;
		acc = r;
		for (int i = DIG_W - 1; i >= 0; i--) begin
			t = {acc, d[i]};
			if (t >= BANKS_C) begin
				t = t - BANKS_C;
			end
			acc = t[BANK_W-1:0];
		end
		return acc;
	endfunction

	seq_state_t state_q, state_d;

	// Latched input word.
	logic [MODE_W-1:0] mode_q;
	logic [KEY_W-1:0]  key_q;
	logic              fr_q;

	// Bank selection.
	logic [BANK_W-1:0] bank_q;
	logic [BANK_W-1:0] rem_q;
	logic [BANK_W-1:0] rem_next;
	logic [PAD_W-1:0]  msh_q;
	logic [DG_W-1:0]   dig_q;
	logic [BANK_W-1:0] in_bank;
	logic [KEY_W-1:0]  in_src;

	// Scan.
	logic [SLOT_W-1:0] slot_q;
	logic              pend_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic              found_q;
	logic [SLOT_W-1:0] hit_slot_q;
	entry_t            hit_q;
	logic              free_ok_q;
	logic [SLOT_W-1:0] free_slot_q;
	logic [ADDR_W-1:0] base_w;
	logic [ADDR_W-1:0] rd_addr;
	entry_t            rd_data;
	logic              rd_valid;
	logic              key_match;

	// Decision and count unit.
	logic                    mode_ok;
	logic                    is_add;
	logic                    sel_visits;
	logic                    step_up;
	logic signed [CNT_W-1:0] opnd;
	logic signed [CNT_W-1:0] bumped;
	logic signed [CNT_W-1:0] new_visits;
	logic signed [CNT_W-1:0] new_claims;
	logic                    out_free;
	logic                    decide_fire;
	store_wr_t               wr_d;
	store_wr_t               wr;
	status_t                 res_status;
	logic                    res_released;
	logic                    res_free;
	logic                    res_client;
	logic signed [CNT_W-1:0] res_visits;
	logic signed [CNT_W-1:0] res_claims;

	// Output register.
	logic                    out_valid_q;
	logic [STATUS_W-1:0]     status_q;
	logic                    released_q;
	logic                    release_free_q;
	logic                    release_client_q;
	logic signed [CNT_W-1:0] visits_now_q;
	logic signed [CNT_W-1:0] claims_now_q;

	srt_entry_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr  (rd_addr),
		.wr       (wr),
		.rd_data  (rd_data),
		.rd_valid (rd_valid)
	);

	// Common decodes.
	assign in_src     = key >> BANK_SHIFT;
	assign in_bank    = BANK_W'(in_src) & BANK_MASK;
	assign rem_next   = mod_step(rem_q, msh_q[PAD_W-1 -: DIG_W]);
	assign base_w     = ADDR_W'(bank_q * EPB_C);
	assign key_match  = rd_valid && (rd_data.key == key_q);
	assign out_free   = !out_valid_q || !out_stall;
	assign mode_ok    = (mode_q <= MODE_UNCLAIM);
	assign is_add     = (mode_q == MODE_ADD_INT) || (mode_q == MODE_ADD_CLIENT);
	assign sel_visits = (mode_q == MODE_VISIT_UP) || (mode_q == MODE_VISIT_DOWN);
	assign step_up    = (mode_q == MODE_VISIT_UP) || (mode_q == MODE_CLAIM);

	// Shared saturating count unit.
	always_comb begin
		opnd = sel_visits ? hit_q.visits : hit_q.claims;
		if (step_up) begin
			bumped = (opnd == CNT_MAX) ? opnd : opnd + CNT_ONE;
		end else begin
			bumped = (opnd == CNT_MIN) ? opnd : opnd - CNT_ONE;
		end
		new_visits = sel_visits ? bumped : hit_q.visits;
		new_claims = sel_visits ? hit_q.claims : bumped;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SEQ_IDLE: begin
				if (in_valid) begin
					if (mode > MODE_UNCLAIM) begin
						state_d = SEQ_DECIDE;
					end else if (BANK_POW2) begin
						state_d = SEQ_SCAN;
					end else begin
						state_d = SEQ_MOD;
					end
				end
			end
			SEQ_MOD: begin
				if (dig_q == DG_LAST) begin
					state_d = SEQ_SCAN;
				end
			end
			SEQ_SCAN: begin
				if (slot_q == SLOT_LAST) begin
					state_d = SEQ_DRAIN;
				end
			end
			SEQ_DRAIN: begin
				state_d = SEQ_DECIDE;
			end
			SEQ_DECIDE: begin
				if (out_free) begin
					state_d = SEQ_IDLE;
				end
			end
			default: begin
				state_d = SEQ_IDLE;
			end
		endcase
	end

	// Sequencer outputs: handshake, read address and the decision.
	always_comb begin
		in_stall     = (state_q != SEQ_IDLE);
		rd_addr      = base_w + ADDR_W'(slot_q);
		decide_fire  = (state_q == SEQ_DECIDE) && out_free;
		wr_d         = '0;
		res_status   = STS_OK;
		res_released = 1'b0;
		res_free     = 1'b0;
		res_client   = 1'b0;
		res_visits   = CNT_ZERO;
		res_claims   = CNT_ZERO;
		if (mode_ok) begin
			if (is_add) begin
				if (found_q || !free_ok_q) begin
					res_status = STS_REFUSED;
				end else begin
					wr_d.wr_en          = 1'b1;
					wr_d.set_valid      = 1'b1;
					wr_d.addr           = base_w + ADDR_W'(free_slot_q);
					wr_d.data.key       = key_q;
					wr_d.data.visits    = CNT_ONE;
					wr_d.data.claims    = CNT_ZERO;
					wr_d.data.free_flag = fr_q;
					wr_d.data.client    = (mode_q == MODE_ADD_CLIENT);
					res_visits          = CNT_ONE;
				end
			end else if (!found_q) begin
				res_status = STS_NOT_FOUND;
			end else begin
				wr_d.addr = base_w + ADDR_W'(hit_slot_q);
				if ((new_visits == CNT_ZERO) && (new_claims == CNT_ZERO)) begin
					wr_d.clr_valid = 1'b1;
					res_released   = 1'b1;
					res_free       = hit_q.free_flag;
					res_client     = hit_q.client;
				end else begin
					wr_d.wr_en       = 1'b1;
					wr_d.data        = hit_q;
					wr_d.data.visits = new_visits;
					wr_d.data.claims = new_claims;
					res_visits       = new_visits;
					res_claims       = new_claims;
					if (new_visits[CNT_W-1] || new_claims[CNT_W-1]) begin
						res_status = STS_NEGATIVE;
					end
				end
			end
		end
		wr = decide_fire ? wr_d : '0;
	end

	// Sequencer state and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SEQ_IDLE;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= (state_q == SEQ_SCAN);
			if (decide_fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Word capture, bank reduction and scan bookkeeping.
	always_ff @(posedge clk) begin
		slot_s1 <= slot_q;
		if ((state_q == SEQ_IDLE) && in_valid) begin
			mode_q    <= mode;
			key_q     <= key;
			fr_q      <= free_on_release;
			bank_q    <= in_bank;
			rem_q     <= '0;
			msh_q     <= PAD_W'(in_src);
			dig_q     <= '0;
			slot_q    <= '0;
			found_q   <= 1'b0;
			free_ok_q <= 1'b0;
		end
		if (state_q == SEQ_MOD) begin
			rem_q <= rem_next;
			msh_q <= msh_q << DIG_W;
			dig_q <= dig_q + DG_W'(1);
			if (dig_q == DG_LAST) begin
				bank_q <= rem_next;
			end
		end
		if (state_q == SEQ_SCAN) begin
			slot_q <= slot_q + SLOT_W'(1);
		end
		// Returned entry: first match and first free slot.
		if (pend_s1) begin
			if (key_match && !found_q) begin
				found_q    <= 1'b1;
				hit_slot_q <= slot_s1;
				hit_q      <= rd_data;
			end
			if (!rd_valid && !free_ok_q) begin
				free_ok_q   <= 1'b1;
				free_slot_q <= slot_s1;
			end
		end
	end

	// Result register, loaded when the previous result has left.
	always_ff @(posedge clk) begin
		if (decide_fire) begin
			status_q         <= res_status;
			released_q       <= res_released;
			release_free_q   <= res_free;
			release_client_q <= res_client;
			visits_now_q     <= res_visits;
			claims_now_q     <= res_claims;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign released       = released_q;
	assign release_free   = release_free_q;
	assign release_client = release_client_q;
	assign visits_now     = visits_now_q;
	assign claims_now     = claims_now_q;

endmodule
`default_nettype wire
